>>> src/bth_pkg.sv
// Shared types and constants for the boundary-tag heap allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bth_pkg;

	// byte addresses are carried wide enough that stray tag arithmetic never
	// wraps back into the heap
	localparam int ADDR_W = 36;
	localparam int WORD_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// layout constants
	localparam int FIRST_BP    = 8;
	localparam int MIN_SPLIT   = 16;
	localparam int LAYOUT_SZ   = 16;
	localparam logic [16:0] GROW_RESET = 17'd4096;

	// tag words
	localparam word_t PROLOGUE_TAG = 32'h0000_000b;
	localparam word_t EPILOGUE_TAG = 32'h0000_0003;
	localparam word_t END_TAG      = 32'h0000_0001;

endpackage

`default_nettype wire

>>> src/bth_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator: first-fit over an implicit block list in one RAM.
// Depends on bth_pkg and bth_ram. One request at a time; one result beat per request.
// The first request, unless it frees address 0, adds 4 lay-out writes and a growth.
// Each tag access is one RAM read or write; read data arrives in the next cycle.
// Reset (arst_n low) clears break, lay-out flag and handshake; heap words are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_heap_allocator
	import bth_pkg::*;
#(
	parameter int HEAP_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        grow_bytes_we,
	input  wire logic [16:0] grow_bytes,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [15:0] request_size,
	input  wire logic [15:0] block_address,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [15:0] result_address,
	output logic             failed
);

	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int IW         = $clog2(HEAP_WORDS);
	localparam int BRK_W      = $clog2(HEAP_BYTES + 1);
	localparam addr_t HEAP_LIM = addr_t'(HEAP_BYTES);

	typedef enum logic [5:0] {
		S_IDLE, S_DISPATCH,
		S_LAY0, S_LAY1, S_LAY2, S_LAY3,
		S_GROW0, S_GROW1, S_GROW2, S_GROW3, S_GRET,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_W2, S_MRET,
		S_FF0, S_FF1, S_NOFIT,
		S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_PL5,
		S_FR0, S_FR1, S_FR2, S_FR3, S_FR4, S_FR5,
		S_DONE
	} state_t;

	function automatic logic in_rng(input addr_t a);
		return (a >> 2) < addr_t'(HEAP_WORDS);
	endfunction

	state_t            state_q;
	logic [BRK_W-1:0]  brk_q;
	logic              init_q, layout_q, gok_q, pa_q, na_q, cmd_q;
	logic [15:0]       size_q, baddr_q;
	logic [16:0]       grow_bytes_q, asize_q, gbytes_q;
	logic [17:0]       gsize_q;
	addr_t             cur_q, mbp_q, nxt_q, prv_q, waddr2_q, mret_q;
	word_t             msz_q, nsz_q, psz_q, csz_q, wval_q;
	logic [15:0]       res_addr_q, out_addr_q;
	logic              res_fail_q, out_fail_q, out_valid_q;
	logic              rd_oob_q;

	// memory port
	logic              mem_we;
	addr_t             mem_waddr, mem_raddr;
	word_t             mem_wdata, ram_q;

	// datapath helpers
	word_t             rdat, hsz, tot_pn_w;
	logic [32:0]       tot_pn;
	logic [33:0]       tot3;
	addr_t             brk_a, bsz_pa;
	logic [14:0]       gw;
	logic [15:0]       gwe;
	logic [17:0]       gsz;
	logic              grow_fail, split, free_bad;
	logic [16:0]       asize_c, size_p;

	bth_ram #(
		.WIDTH(WORD_W),
		.DEPTH(HEAP_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we & in_rng(mem_waddr)),
		.waddr(mem_waddr[IW+1:2]),
		.wdata(mem_wdata),
		.raddr(mem_raddr[IW+1:2]),
		.rdata(ram_q)
	);

	// read data: words outside the heap read as zero
	assign rdat     = rd_oob_q ? '0 : ram_q;
	assign hsz      = {rdat[31:3], 3'b000};
	assign brk_a    = addr_t'(brk_q);
	assign tot_pn   = {1'b0, msz_q} + {1'b0, hsz};
	assign tot_pn_w = tot_pn[31:0] | 32'h2;
	assign tot3     = {2'b00, msz_q} + {2'b00, psz_q} + {2'b00, hsz};
	assign bsz_pa   = in_rng(mbp_q - addr_t'(4)) ? addr_t'({tot_pn[31:3], 3'b000}) : '0;

	// growth size: whole words rounded up to an even count, zero becomes 8
	assign gw        = gbytes_q[16:2];
	assign gwe       = {1'b0, gw} + {15'b0, gw[0]};
	assign gsz       = (gwe == '0) ? 18'd8 : {gwe, 2'b00};
	assign grow_fail = (brk_a + addr_t'(gsz)) > HEAP_LIM;

	assign split    = addr_t'(hsz) >= (addr_t'(asize_q) + addr_t'(MIN_SPLIT));
	assign free_bad = (baddr_q[2:0] != 3'b000) || (baddr_q < 16'd16) ||
		(addr_t'(baddr_q) >= brk_a);

	// block size for a request: 8 bytes minimum, else payload plus header to 8
	assign size_p  = {1'b0, size_q} + 17'd11;
	assign asize_c = (size_q <= 16'd4) ? 17'd8 : {size_p[16:3], 3'b000};

	// memory requests per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			S_LAY0: begin
				mem_we = 1'b1; mem_waddr = cur_q; mem_wdata = '0;
			end
			S_LAY1: begin
				mem_we = 1'b1; mem_waddr = cur_q + addr_t'(4); mem_wdata = PROLOGUE_TAG;
			end
			S_LAY2: begin
				mem_we = 1'b1; mem_waddr = cur_q + addr_t'(8); mem_wdata = PROLOGUE_TAG;
			end
			S_LAY3: begin
				mem_we = 1'b1; mem_waddr = cur_q + addr_t'(12); mem_wdata = EPILOGUE_TAG;
			end
			S_GROW0: mem_raddr = brk_a - addr_t'(4);
			S_GROW1: begin
				mem_we    = 1'b1;
				mem_waddr = mbp_q - addr_t'(4);
				mem_wdata = word_t'(gsize_q) | {30'b0, rdat[1], 1'b0};
			end
			S_GROW2: begin
				mem_we = 1'b1; mem_waddr = mbp_q + addr_t'(gsize_q) - addr_t'(8);
				mem_wdata = wval_q;
			end
			S_GROW3: begin
				mem_we = 1'b1; mem_waddr = mbp_q + addr_t'(gsize_q) - addr_t'(4);
				mem_wdata = END_TAG;
			end
			S_M0: mem_raddr = mbp_q - addr_t'(4);
			S_M1: mem_raddr = mbp_q + addr_t'(hsz) - addr_t'(4);
			S_M2: begin
				if (pa_q && !rdat[0]) begin
					mem_we = 1'b1; mem_waddr = mbp_q - addr_t'(4); mem_wdata = tot_pn_w;
				end else begin
					mem_raddr = mbp_q - addr_t'(8);
				end
			end
			S_M3: mem_raddr = mbp_q - addr_t'(hsz) - addr_t'(4);
			S_M4: begin
				if (na_q) begin
					mem_we    = 1'b1;
					mem_waddr = mbp_q + addr_t'(msz_q) - addr_t'(8);
					mem_wdata = tot_pn_w;
				end else begin
					mem_raddr = nxt_q + addr_t'(nsz_q) - addr_t'(8);
				end
			end
			S_M5: begin
				mem_we = 1'b1; mem_waddr = prv_q - addr_t'(4);
				mem_wdata = tot3[31:0] | 32'h2;
			end
			S_W2: begin
				mem_we = 1'b1; mem_waddr = waddr2_q; mem_wdata = wval_q;
			end
			S_FF0, S_PL0, S_FR0: mem_raddr = cur_q - addr_t'(4);
			S_PL1: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q - addr_t'(4);
				mem_wdata = split ? (word_t'(asize_q) | 32'h3) : (hsz | 32'h3);
			end
			S_PL2: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q + addr_t'(asize_q) - addr_t'(4);
				mem_wdata = (csz_q - word_t'(asize_q)) | 32'h2;
			end
			S_PL3: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q + addr_t'(csz_q) - addr_t'(8);
				mem_wdata = (csz_q - word_t'(asize_q)) | 32'h2;
			end
			S_PL4: mem_raddr = cur_q + addr_t'(csz_q) - addr_t'(4);
			S_PL5: begin
				mem_we = 1'b1; mem_waddr = cur_q + addr_t'(csz_q) - addr_t'(4);
				mem_wdata = rdat | 32'h2;
			end
			S_FR1: begin
				mem_we = 1'b1; mem_waddr = cur_q - addr_t'(4);
				mem_wdata = hsz | {30'b0, rdat[1], 1'b0};
			end
			S_FR2: begin
				mem_we = 1'b1; mem_waddr = cur_q + addr_t'(csz_q) - addr_t'(8);
				mem_wdata = wval_q;
			end
			S_FR3: mem_raddr = cur_q + addr_t'(csz_q) - addr_t'(4);
			S_FR4: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q + addr_t'(csz_q) - addr_t'(4);
				mem_wdata = rdat[0] ? (hsz | 32'h1) : hsz;
			end
			S_FR5: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q + addr_t'(csz_q) + addr_t'(nsz_q) - addr_t'(8);
				mem_wdata = nsz_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			brk_q        <= '0;
			init_q       <= 1'b0;
			layout_q     <= 1'b0;
			gok_q        <= 1'b0;
			pa_q         <= 1'b0;
			na_q         <= 1'b0;
			cmd_q        <= CMD_ALLOC;
			size_q       <= '0;
			baddr_q      <= '0;
			grow_bytes_q <= GROW_RESET;
			asize_q      <= '0;
			gbytes_q     <= '0;
			gsize_q      <= '0;
			cur_q        <= '0;
			mbp_q        <= '0;
			nxt_q        <= '0;
			prv_q        <= '0;
			waddr2_q     <= '0;
			mret_q       <= '0;
			msz_q        <= '0;
			nsz_q        <= '0;
			psz_q        <= '0;
			csz_q        <= '0;
			wval_q       <= '0;
			res_addr_q   <= '0;
			res_fail_q   <= 1'b0;
			out_addr_q   <= '0;
			out_fail_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			rd_oob_q     <= 1'b0;
		end else begin
			rd_oob_q <= !in_rng(mem_raddr);
			if (grow_bytes_we) begin
				grow_bytes_q <= grow_bytes;
			end
			// a beat taken while a new one is loaded is handled in S_DONE
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						size_q  <= request_size;
						baddr_q <= block_address;
						if (command == CMD_FREE && block_address == '0) begin
							res_addr_q <= '0; res_fail_q <= 1'b0;
							state_q    <= S_DONE;
						end else if (!init_q) begin
							init_q <= 1'b1;
							if (brk_a + addr_t'(LAYOUT_SZ) > HEAP_LIM) begin
								state_q <= S_DISPATCH;
							end else begin
								cur_q    <= brk_a;
								brk_q    <= BRK_W'(brk_a + addr_t'(LAYOUT_SZ));
								gbytes_q <= grow_bytes_q;
								layout_q <= 1'b1;
								state_q  <= S_LAY0;
							end
						end else begin
							state_q <= S_DISPATCH;
						end
					end
				end
				S_LAY0: state_q <= S_LAY1;
				S_LAY1: state_q <= S_LAY2;
				S_LAY2: state_q <= S_LAY3;
				S_LAY3: state_q <= S_GROW0;

				// heap growth
				S_GROW0: begin
					if (grow_fail) begin
						gok_q   <= 1'b0;
						state_q <= S_GRET;
					end else begin
						mbp_q   <= brk_a;
						brk_q   <= BRK_W'(brk_a + addr_t'(gsz));
						gsize_q <= gsz;
						state_q <= S_GROW1;
					end
				end
				S_GROW1: begin
					wval_q  <= word_t'(gsize_q) | {30'b0, rdat[1], 1'b0};
					state_q <= S_GROW2;
				end
				S_GROW2: state_q <= S_GROW3;
				S_GROW3: state_q <= S_M0;
				S_GRET: begin
					if (layout_q) begin
						layout_q <= 1'b0;
						state_q  <= S_DISPATCH;
					end else if (!gok_q || mret_q == '0) begin
						res_addr_q <= '0; res_fail_q <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						cur_q   <= mret_q;
						state_q <= S_PL0;
					end
				end

				// coalescing with neighbors
				S_M0: state_q <= S_M1;
				S_M1: begin
					pa_q    <= rdat[1];
					msz_q   <= hsz;
					nxt_q   <= mbp_q + addr_t'(hsz);
					state_q <= S_M2;
				end
				S_M2: begin
					na_q  <= rdat[0];
					nsz_q <= hsz;
					if (pa_q && rdat[0]) begin
						mret_q  <= mbp_q;
						state_q <= S_MRET;
					end else if (pa_q) begin
						waddr2_q <= mbp_q + bsz_pa - addr_t'(8);
						wval_q   <= tot_pn_w;
						mret_q   <= mbp_q;
						state_q  <= S_W2;
					end else begin
						state_q <= S_M3;
					end
				end
				S_M3: begin
					prv_q   <= mbp_q - addr_t'(hsz);
					state_q <= S_M4;
				end
				S_M4: begin
					psz_q <= hsz;
					if (na_q) begin
						waddr2_q <= prv_q - addr_t'(4);
						wval_q   <= tot_pn_w;
						mret_q   <= prv_q;
						state_q  <= S_W2;
					end else begin
						state_q <= S_M5;
					end
				end
				S_M5: begin
					waddr2_q <= nxt_q + addr_t'(nsz_q) - addr_t'(8);
					wval_q   <= tot3[31:0] | 32'h2;
					mret_q   <= prv_q;
					state_q  <= S_W2;
				end
				S_W2: state_q <= S_MRET;
				S_MRET: begin
					if (cmd_q == CMD_FREE && !layout_q) begin
						res_addr_q <= '0; res_fail_q <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						gok_q   <= 1'b1;
						state_q <= S_GRET;
					end
				end

				// request decode after lay-out
				S_DISPATCH: begin
					if (cmd_q == CMD_ALLOC) begin
						if (size_q == '0) begin
							res_addr_q <= '0; res_fail_q <= 1'b1;
							state_q    <= S_DONE;
						end else begin
							asize_q <= asize_c;
							cur_q   <= addr_t'(FIRST_BP);
							state_q <= S_FF0;
						end
					end else if (free_bad) begin
						res_addr_q <= '0; res_fail_q <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						cur_q   <= addr_t'(baddr_q);
						mbp_q   <= addr_t'(baddr_q);
						state_q <= S_FR0;
					end
				end

				// first-fit walk over the block headers
				S_FF0: state_q <= (cur_q > brk_a) ? S_NOFIT : S_FF1;
				S_FF1: begin
					if (hsz == '0) begin
						state_q <= S_NOFIT;
					end else if (!rdat[0] && (word_t'(asize_q) <= hsz)) begin
						state_q <= S_PL0;
					end else begin
						cur_q   <= cur_q + addr_t'(hsz);
						state_q <= S_FF0;
					end
				end
				S_NOFIT: begin
					gbytes_q <= (asize_q > grow_bytes_q) ? asize_q : grow_bytes_q;
					state_q  <= S_GROW0;
				end

				// placement
				S_PL0: state_q <= S_PL1;
				S_PL1: begin
					csz_q   <= hsz;
					state_q <= split ? S_PL2 : S_PL4;
				end
				S_PL2: state_q <= S_PL3;
				S_PL3, S_PL5: begin
					res_addr_q <= cur_q[15:0]; res_fail_q <= 1'b0;
					state_q    <= S_DONE;
				end
				S_PL4: state_q <= S_PL5;

				// release
				S_FR0: state_q <= S_FR1;
				S_FR1: begin
					csz_q   <= hsz;
					wval_q  <= hsz | {30'b0, rdat[1], 1'b0};
					state_q <= S_FR2;
				end
				S_FR2: state_q <= S_FR3;
				S_FR3: state_q <= S_FR4;
				S_FR4: begin
					nsz_q   <= hsz;
					state_q <= rdat[0] ? S_M0 : S_FR5;
				end
				S_FR5: state_q <= S_M0;

				// result beat into the output register
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= res_addr_q;
						out_fail_q  <= res_fail_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign failed         = out_fail_q;

	// checks
	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		addr_t'(brk_q) <= HEAP_LIM)
		else $error("heap break beyond heap");
	a_brk_align: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q[2:0] == 3'b000)
		else $error("heap break not 8-byte aligned");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> result_address == '0)
		else $error("failed beat carries an address");
	a_init_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |=> init_q)
		else $error("lay-out flag dropped");

endmodule

`default_nettype wire

>>> bench/boundary_tag_heap_allocator_tb.sv
// Self-checking bench for boundary_tag_heap_allocator: predicts each result beat
// from its own heap-tag model. Depends on bth_pkg and the allocator RTL.
`timescale 1ns / 1ps

module boundary_tag_heap_allocator_tb;
	import bth_pkg::*;

	localparam int HEAP_SZ = 65536;
	localparam int HEAP_WD = HEAP_SZ / 4;
	localparam int STUCK_LIMIT = 200000;

	typedef struct {
		logic        cmd;
		logic [15:0] size;
		logic [15:0] addr;
		bit          pick_live;
	} req_t;

	typedef struct packed {
		logic [15:0] addr;
		logic        fail;
	} alloc_res_t;

	logic        clk;
	logic        arst_n;
	logic        grow_bytes_we;
	logic [16:0] grow_bytes;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [15:0] request_size;
	logic [15:0] block_address;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] result_address;
	logic        failed;

	boundary_tag_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.grow_bytes_we(grow_bytes_we), .grow_bytes(grow_bytes),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .request_size(request_size), .block_address(block_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_address(result_address), .failed(failed)
	);

	// shadow heap state
	logic [31:0] heap_img [0:HEAP_WD-1];
	logic [63:0] brk;
	bit          laid_out;
	logic [63:0] grow_amt;

	req_t        pending_reqs[$];
	alloc_res_t  expected_res[$];
	logic [15:0] live_blocks[$];
	int          error_count;
	int          stuck_cycles;
	bit          in_took;
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] tag_rd(logic [63:0] a);
		logic [63:0] i;
		i = a >> 2;
		if (i < HEAP_WD)
			return heap_img[i];
		return 32'd0;
	endfunction

	function automatic void tag_wr(logic [63:0] a, logic [63:0] v);
		logic [63:0] i;
		i = a >> 2;
		if (i < HEAP_WD)
			heap_img[i] = v[31:0];
	endfunction

	function automatic logic [63:0] blk_bytes(logic [63:0] bp);
		return {32'd0, tag_rd(bp - 4) & ~32'd7};
	endfunction

	// merge a free block with free neighbors, four cases
	function automatic logic [63:0] coalesce(logic [63:0] bp);
		logic        pa, na;
		logic [63:0] sz, nxt, prv, nftr;
		logic [31:0] t;
		t = tag_rd(bp - 4);
		pa = t[1];
		sz = blk_bytes(bp);
		nxt = bp + sz;
		t = tag_rd(nxt - 4);
		na = t[0];
		if (pa && na)
			return bp;
		if (pa) begin
			sz += blk_bytes(nxt);
			tag_wr(bp - 4, sz | 2);
			tag_wr(bp + blk_bytes(bp) - 8, sz | 2);
			return bp;
		end
		prv = bp - {32'd0, tag_rd(bp - 8) & ~32'd7};
		if (na) begin
			sz += blk_bytes(prv);
			tag_wr(bp + blk_bytes(bp) - 8, sz | 2);
			tag_wr(prv - 4, sz | 2);
			return prv;
		end
		sz += blk_bytes(prv) + {32'd0, tag_rd(nxt + blk_bytes(nxt) - 8) & ~32'd7};
		nftr = nxt + blk_bytes(nxt) - 8;
		tag_wr(prv - 4, sz | 2);
		tag_wr(nftr, sz | 2);
		return prv;
	endfunction

	function automatic logic [63:0] grow_img(logic [63:0] bytes);
		logic [63:0] words, sz, bp, w;
		logic [31:0] t;
		words = bytes >> 2;
		if (words[0])
			words++;
		sz = words << 2;
		if (sz == 0)
			sz = 8;
		if (brk + sz > HEAP_SZ)
			return 0;
		bp = brk;
		brk = bp + sz;
		t = tag_rd(bp - 4);
		w = sz | {62'd0, t[1], 1'b0};
		tag_wr(bp - 4, w);
		tag_wr(bp + sz - 8, w);
		tag_wr(bp + sz - 4, 1);
		return coalesce(bp);
	endfunction

	function automatic void lay_heap();
		logic [63:0] base, unused;
		base = brk;
		laid_out = 1;
		if (base + 16 > HEAP_SZ)
			return;
		brk = base + 16;
		tag_wr(base, 0);
		tag_wr(base + 4, 11);
		tag_wr(base + 8, 11);
		tag_wr(base + 12, 3);
		unused = grow_img(grow_amt);
	endfunction

	function automatic logic [63:0] scan_fit(logic [63:0] asize);
		logic [63:0] bp, s;
		logic [31:0] t;
		bp = FIRST_BP;
		while (bp <= brk) begin
			s = blk_bytes(bp);
			if (s == 0)
				return 0;
			t = tag_rd(bp - 4);
			if (!t[0] && asize <= s)
				return bp;
			bp += s;
		end
		return 0;
	endfunction

	// split when the remainder is big enough, else take the whole block and mark the next header
	function automatic void carve(logic [63:0] bp, logic [63:0] asize);
		logic [63:0] c, r, n;
		c = blk_bytes(bp);
		if (c >= asize + MIN_SPLIT) begin
			r = bp + asize;
			tag_wr(bp - 4, asize | 3);
			tag_wr(r - 4, (c - asize) | 2);
			tag_wr(r + (c - asize) - 8, (c - asize) | 2);
		end else begin
			n = bp + c;
			tag_wr(bp - 4, c | 3);
			tag_wr(n - 4, tag_rd(n - 4) | 2);
		end
	endfunction

	function automatic void free_block(logic [63:0] bp);
		logic [63:0] sz, nxt, ns, unused;
		logic [31:0] w, t;
		if (!laid_out)
			lay_heap();
		if (bp[2:0] != 0 || bp < 16 || bp >= brk)
			return;
		sz = blk_bytes(bp);
		w = sz[31:0] | (tag_rd(bp - 4) & 32'd2);
		tag_wr(bp - 4, w);
		tag_wr(bp + sz - 8, w);
		nxt = bp + blk_bytes(bp);
		ns = blk_bytes(nxt);
		t = tag_rd(nxt - 4);
		if (t[0]) begin
			tag_wr(nxt - 4, ns | 1);
		end else begin
			tag_wr(nxt - 4, ns);
			tag_wr(nxt + ns - 8, ns);
		end
		unused = coalesce(bp);
	endfunction

	function automatic alloc_res_t predict_result(logic cmd, logic [15:0] sz, logic [15:0] a);
		alloc_res_t  r;
		logic [63:0] asize, bp, ext;
		r = '0;
		if (cmd == CMD_FREE) begin
			if (a != 0)
				free_block({48'd0, a});
			return r;
		end
		if (!laid_out)
			lay_heap();
		if (sz == 0) begin
			r.fail = 1'b1;
			return r;
		end
		asize = (sz <= 4) ? 64'd8 : 64'd8 * ((sz + 64'd11) / 8);
		bp = scan_fit(asize);
		if (bp == 0) begin
			ext = (asize > grow_amt) ? asize : grow_amt;
			bp = grow_img(ext);
			if (bp == 0) begin
				r.fail = 1'b1;
				return r;
			end
		end
		carve(bp, asize);
		r.addr = bp[15:0];
		live_blocks.push_back(bp[15:0]);
		return r;
	endfunction

	// request side: accept beats, predict, watchdog
	always @(posedge clk) begin
		alloc_res_t r;
		in_took <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			r = predict_result(command, request_size, block_address);
			expected_res.push_back(r);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: compare against the oldest prediction
	always @(posedge clk) begin
		alloc_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_res.size() == 0) begin
				$error("unexpected result beat: result_address %0d failed %0d",
					result_address, failed);
				error_count++;
			end else begin
				e = expected_res.pop_front();
				if (result_address !== e.addr) begin
					$error("result_address expected %0d actual %0d", e.addr, result_address);
					error_count++;
				end
				if (failed !== e.fail) begin
					$error("failed expected %0d actual %0d", e.fail, failed);
					error_count++;
				end
			end
		end
	end

	// driver: present the next request beat, hold it while stalled
	always @(negedge clk) begin
		req_t        q;
		int          k;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 22);
			if (in_valid && !in_took) begin
				in_valid <= 1'b1;
			end else if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
				q = pending_reqs.pop_front();
				if (q.pick_live) begin
					if (live_blocks.size() > 0) begin
						k = $urandom_range(0, live_blocks.size() - 1);
						q.addr = live_blocks[k];
						live_blocks.delete(k);
					end else begin
						q.addr = 16'd0;
					end
				end
				command <= q.cmd;
				request_size <= q.size;
				block_address <= q.addr;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	function automatic req_t mk_req(logic cmd, logic [15:0] sz, logic [15:0] a, bit live);
		req_t q;
		q.cmd = cmd;
		q.size = sz;
		q.addr = a;
		q.pick_live = live;
		return q;
	endfunction

	function automatic req_t rand_req();
		int          p;
		logic [15:0] sz;
		p = $urandom_range(0, 99);
		if (p < 42)
			return mk_req(CMD_FREE, 16'($urandom), 16'd0, 1);
		// noise frees: misaligned or below the first block, always ignored
		if (p < 47)
			return mk_req(CMD_FREE, 16'($urandom), 16'($urandom | $urandom_range(1, 7)), 0);
		if (p < 49)
			return mk_req(CMD_FREE, 16'($urandom), 16'($urandom_range(0, 15)), 0);
		p = $urandom_range(0, 99);
		if (p < 3)
			sz = 16'd0;
		else if (p < 75)
			sz = 16'($urandom_range(1, 160));
		else if (p < 93)
			sz = 16'($urandom_range(161, 3000));
		else if (p < 98)
			sz = 16'($urandom_range(3001, 20000));
		else
			sz = 16'($urandom_range(20001, 65535));
		return mk_req(CMD_ALLOC, sz, 16'($urandom), 0);
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_grow(logic [16:0] v);
		@(negedge clk);
		grow_bytes_we <= 1'b1;
		grow_bytes <= v;
		grow_amt = {47'd0, v};
		@(negedge clk);
		grow_bytes_we <= 1'b0;
	endtask

	initial begin
		logic [16:0] grow_set [5];
		grow_set = '{17'd8, 17'd65536, 17'd512, 17'd24, 17'd4096};
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		command = CMD_ALLOC;
		request_size = '0;
		block_address = '0;
		grow_bytes_we = 1'b0;
		grow_bytes = GROW_RESET;
		error_count = 0;
		stuck_cycles = 0;
		in_took = 0;
		calm = 0;
		brk = 0;
		laid_out = 0;
		grow_amt = {47'd0, GROW_RESET};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_grow(17'd4096);

		// directed: lay-out by free, bad frees, size extremes, merges
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'hFFF8, 0));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd0, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd1, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd4, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd5, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd12, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd13, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'hFFFF, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'd3, 0));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'd8, 0));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'hFFF8, 0));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 0));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'd0, 1));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'd0, 1));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd4000, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'd0, 1));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'd0, 1));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd8, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_ALLOC, 16'd100, 16'd0, 0));
		pending_reqs.push_back(mk_req(CMD_FREE, 16'd0, 16'd0, 1));
		wait_drained();

		// random phases, one growth setting each; the third runs with no idling
		for (int ph = 0; ph < 5; ph++) begin
			set_grow(grow_set[ph]);
			calm = (ph == 2);
			for (int n = 0; n < 126; n++)
				pending_reqs.push_back(rand_req());
			wait_drained();
		end

		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
